// ===== src/assert_macros.svh =====
// Assertion macros used by the converter datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== src/itp_pkg.sv =====
// Types, codes and helper functions of the infix-to-postfix token converter.
`timescale 1ns / 1ps

package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam int KIND_W  = 3;
   localparam int CODE_W  = 3;
   localparam int VALUE_W = 32;
   localparam int TYPE_W  = 2;
   localparam int ENTRY_W = TYPE_W + CODE_W;
   localparam int DATA_W  = 40;

   // Input token kinds.
   localparam logic [KIND_W-1:0] KIND_NUMBER   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FUNCTION = 3'd2;
   localparam logic [KIND_W-1:0] KIND_OPEN     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLOSE    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_END      = 3'd5;

   // Result kinds.
   localparam logic [KIND_W-1:0] OUT_NUMBER   = 3'd0;
   localparam logic [KIND_W-1:0] OUT_OPERATOR = 3'd1;
   localparam logic [KIND_W-1:0] OUT_FUNCTION = 3'd2;
   localparam logic [KIND_W-1:0] OUT_PAREN    = 3'd3;
   localparam logic [KIND_W-1:0] OUT_END      = 3'd4;

   // Operator codes.
   localparam logic [CODE_W-1:0] OP_PLUS   = 3'd0;
   localparam logic [CODE_W-1:0] OP_MINUS  = 3'd1;
   localparam logic [CODE_W-1:0] OP_TIMES  = 3'd2;
   localparam logic [CODE_W-1:0] OP_DIVIDE = 3'd3;
   localparam logic [CODE_W-1:0] OP_MODULO = 3'd4;
   localparam logic [CODE_W-1:0] OP_POWER  = 3'd5;

   localparam logic [CODE_W-1:0] FUNC_LAST = 3'd6;

   // Stack entry types.
   localparam logic [TYPE_W-1:0] TYPE_OP    = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_FUNC  = 2'd2;
   localparam logic [TYPE_W-1:0] TYPE_PAREN = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CODE_W-1:0]  op;
      logic [CODE_W-1:0]  func;
      logic [VALUE_W-1:0] value;
      logic               error;
   } result_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_token;
      logic emit_number;
      logic emit_top;
      logic emit_end;
      logic pop_only;
      logic push;
      logic set_error;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [KIND_W-1:0] tok_kind;
      logic              op_bad;
      logic              func_bad;
      logic              empty;
      logic [TYPE_W-1:0] top_type;
      logic              op_pops;
      logic              can_emit;
   } stat_type;

   function automatic logic [1:0] op_prec(input logic [CODE_W-1:0] code);
      logic [1:0] prec;
      case (code) inside
         OP_PLUS, OP_MINUS:             prec = 2'd1;
         OP_TIMES, OP_DIVIDE, OP_MODULO: prec = 2'd2;
         default:                       prec = 2'd3;
      endcase
      return prec;
   endfunction

endpackage

// ===== src/itp_dp.sv =====
// Datapath: token register, operator stack, error latch and result registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itp_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [itp_pkg::KIND_W-1:0]  tok_kind,
   input  logic [itp_pkg::CODE_W-1:0]  tok_op,
   input  logic [itp_pkg::CODE_W-1:0]  tok_func,
   input  logic [itp_pkg::VALUE_W-1:0] tok_value,
   input  itp_pkg::cmd_type           cmd,
   output itp_pkg::stat_type          stat,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output itp_pkg::result_type        rsp_result,
   output logic                      rsp_last
);
   import itp_pkg::*;

   logic [KIND_W-1:0]  kind_ff;
   logic [CODE_W-1:0]  op_ff;
   logic [CODE_W-1:0]  func_ff;
   logic [VALUE_W-1:0] value_ff;

   logic [ENTRY_W-1:0] stack_ff [STACK_DEPTH];
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               err_ff, err_in;

   result_type hold_ff, hold_in;
   logic       hold_valid_ff, hold_valid_in;
   result_type out_ff, out_in;
   logic       out_last_ff, out_last_in;
   logic       out_valid_ff, out_valid_in;

   logic [PTR_W-1:0]   top_idx;
   logic [ENTRY_W-1:0] top_entry;
   logic [ENTRY_W-1:0] push_entry;
   logic               full;
   logic               stack_we;
   logic               any_emit;
   logic               out_free;
   result_type         new_res;

   assign top_idx   = PTR_W'(cnt_ff - CNT_W'(1));
   assign top_entry = stack_ff[top_idx];
   assign full      = (cnt_ff == CNT_W'(STACK_DEPTH));
   assign out_free  = !out_valid_ff || rsp_ready;
   assign any_emit  = cmd.emit_number || cmd.emit_top || cmd.emit_end;

   // Status for the controller.
   always_comb begin
      stat.tok_kind = kind_ff;
      stat.op_bad   = (op_ff > OP_POWER);
      stat.func_bad = (func_ff > FUNC_LAST);
      stat.empty    = (cnt_ff == '0);
      stat.top_type = top_entry[ENTRY_W-1:CODE_W];
      stat.op_pops  = (op_prec(top_entry[CODE_W-1:0]) > op_prec(op_ff)) ||
                      ((op_prec(top_entry[CODE_W-1:0]) == op_prec(op_ff)) &&
                       (op_ff != OP_POWER));
      stat.can_emit = out_free || !hold_valid_ff;
   end

   always_comb begin
      case (kind_ff)
         KIND_OPERATOR: push_entry = {TYPE_OP, op_ff};
         KIND_FUNCTION: push_entry = {TYPE_FUNC, func_ff};
         default:       push_entry = {TYPE_PAREN, CODE_W'(0)};
      endcase
   end

   always_comb begin
      new_res = '0;
      if (cmd.emit_number) begin
         new_res.kind  = OUT_NUMBER;
         new_res.value = value_ff;
      end else if (cmd.emit_end) begin
         new_res.kind  = OUT_END;
         new_res.error = err_ff;
      end else begin
         case (top_entry[ENTRY_W-1:CODE_W])
            TYPE_OP: begin
               new_res.kind = OUT_OPERATOR;
               new_res.op   = top_entry[CODE_W-1:0];
            end
            TYPE_FUNC: begin
               new_res.kind = OUT_FUNCTION;
               new_res.func = top_entry[CODE_W-1:0];
            end
            default: new_res.kind = OUT_PAREN;
         endcase
      end
   end

   // One result waits in the hold register until it is known whether it is
   // the last one of its token; the one before it moves to the output.
   always_comb begin
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      stack_we      = 1'b0;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      if (cmd.emit_top || cmd.pop_only) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (cmd.push) begin
         if (full) begin
            err_in = 1'b1;
         end else begin
            stack_we = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.set_error) begin
         err_in = 1'b1;
      end
      if (cmd.emit_end) begin
         err_in = 1'b0;
      end

      if (any_emit) begin
         hold_in       = new_res;
         hold_valid_in = 1'b1;
         if (hold_valid_ff) begin
            out_in       = hold_ff;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
         end
      end
      if (cmd.finish && hold_valid_ff) begin
         out_in        = hold_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         err_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         err_ff        <= err_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      if (cmd.load_token) begin
         kind_ff  <= tok_kind;
         op_ff    <= tok_op;
         func_ff  <= tok_func;
         value_ff <= tok_value;
      end
      if (stack_we) begin
         stack_ff[cnt_ff[PTR_W-1:0]] <= push_entry;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;
   assign rsp_last   = out_last_ff;

   `ASSERT_NEVER(a_count_in_range, clock, reset, cnt_ff > CNT_W'(STACK_DEPTH))
   `ASSERT_NEVER(a_emit_needs_room, clock, reset, any_emit && !stat.can_emit)
   `ASSERT_PROP(a_end_clears_error, clock, reset, cmd.emit_end |=> !err_ff)
   `ASSERT_PROP(a_overflow_sets_error, clock, reset, (cmd.push && full) |=> err_ff)

endmodule

// ===== src/itp_ctrl.sv =====
// Controller: sequences the stack pops, pushes and result emission per token.
`timescale 1ns / 1ps

module itp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itp_pkg::stat_type stat,
   output itp_pkg::cmd_type  cmd
);
   import itp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_WORK     = 4'b0010,
      ST_CLOSE_FN = 4'b0100,
      ST_FINISH   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_token = 1'b1;
               state_in       = ST_WORK;
            end
         end

         ST_WORK: begin
            unique case (stat.tok_kind)
               KIND_NUMBER: begin
                  if (stat.can_emit) begin
                     cmd.emit_number = 1'b1;
                     state_in        = ST_FINISH;
                  end
               end
               KIND_OPERATOR: begin
                  if (stat.op_bad) begin
                     cmd.set_error = 1'b1;
                     state_in      = ST_FINISH;
                  end else if (!stat.empty && stat.top_type == TYPE_OP && stat.op_pops) begin
                     cmd.emit_top = stat.can_emit;
                  end else begin
                     cmd.push = 1'b1;
                     state_in = ST_FINISH;
                  end
               end
               KIND_FUNCTION: begin
                  cmd.set_error = stat.func_bad;
                  cmd.push      = !stat.func_bad;
                  state_in      = ST_FINISH;
               end
               KIND_OPEN: begin
                  cmd.push = 1'b1;
                  state_in = ST_FINISH;
               end
               KIND_CLOSE: begin
                  if (!stat.empty && stat.top_type != TYPE_PAREN) begin
                     cmd.emit_top = stat.can_emit;
                  end else if (!stat.empty) begin
                     // Drop the matching open parenthesis.
                     cmd.pop_only = 1'b1;
                     state_in     = ST_CLOSE_FN;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               KIND_END: begin
                  if (stat.can_emit) begin
                     if (!stat.empty) begin
                        cmd.emit_top = 1'b1;
                     end else begin
                        cmd.emit_end = 1'b1;
                        state_in     = ST_FINISH;
                     end
                  end
               end
               default: begin
                  cmd.set_error = 1'b1;
                  state_in      = ST_FINISH;
               end
            endcase
         end

         ST_CLOSE_FN: begin
            if (!stat.empty && stat.top_type == TYPE_FUNC) begin
               if (stat.can_emit) begin
                  cmd.emit_top = 1'b1;
                  state_in     = ST_FINISH;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // The held result leaves as the token's last; a new token may
            // be taken in the same cycle.
            if (stat.can_emit) begin
               cmd.finish = 1'b1;
               req_ready  = 1'b1;
               if (req_valid) begin
                  cmd.load_token = 1'b1;
                  state_in       = ST_WORK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/infix_to_postfix_token_converter_top.sv =====
// Top level of the shunting-yard infix-to-postfix token converter.
`timescale 1ns / 1ps

// Takes classified infix tokens on the req_ stream and returns postfix tokens on
// the rsp_ stream, with rsp_tlast on the final result of each input token (push-only
// and rejected tokens give no result). One token is worked at a time: a number is
// emitted; a function or open parenthesis is pushed; a rejected token sets the
// error flag; an operator pops the stacked operators that take precedence, then is
// pushed; a close parenthesis pops the entries above the open parenthesis, drops it
// and lets a function under it leave; the end token flushes the stack, then emits
// the end marker. The controller pops at most one entry of the 32-entry operator
// stack per cycle, and a pop that emits waits for room in the single output
// register, so a stalled rsp_tready holds the work. No clearing pass is needed
// after reset. An unknown kind, operator or function code or a push onto a full
// stack sets an error flag that the end marker carries and then clears.
module infix_to_postfix_token_converter_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // op_code[2:0], func_code[5:3], number_value[37:6], zero[39:38]
   input  logic [itp_pkg::DATA_W-1:0]  req_tdata,
   // kind[2:0]
   input  logic [itp_pkg::KIND_W-1:0]  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_op[2:0], out_func[5:3], out_value[37:6], error[38], zero[39]
   output logic [itp_pkg::DATA_W-1:0]  rsp_tdata,
   // out_kind[2:0]
   output logic [itp_pkg::KIND_W-1:0]  rsp_tuser,
   output logic                        rsp_tlast
);
   import itp_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   result_type result;

   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   itp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .tok_kind   (req_tuser),
      .tok_op     (req_tdata[2:0]),
      .tok_func   (req_tdata[5:3]),
      .tok_value  (req_tdata[37:6]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, result.error, result.value, result.func, result.op};
   assign rsp_tuser = result.kind;

endmodule
